// File: rtl/sls_pkg.sv
// Shared types and codes for the sorting LIFO stack.
// Request and result structs, command and status codes, default depth.
// No dependencies.
package sls_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] CMD_PUSH     = 3'd0;
    localparam logic [2:0] CMD_POP      = 3'd1;
    localparam logic [2:0] CMD_PEEK     = 3'd2;
    localparam logic [2:0] CMD_POP_BOT  = 3'd3;
    localparam logic [2:0] CMD_SORT     = 3'd4;
    localparam logic [2:0] CMD_INSERT   = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value_in;
    } sls_req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic [6:0]         count;
    } sls_rsp_t;

endpackage

// File: rtl/sorting_lifo_stack_core.sv
// Top level of the sorting LIFO stack: command sequencer around one entry memory.
// Depends on sls_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready/in_data (cmd, value_in); one result
//   per request leaves on out_valid/out_ready/out_data (value_out, status,
//   count). A request is taken only while the sequencer is idle; the result
//   sits in an output register, so the next request can be taken while the
//   previous result still waits for out_ready.
//   Entries live in a DEPTH x 32 synchronous RAM (one read, one write port,
//   registered read data); only the fill count is in flip-flops.
//   Command flow from acceptance to out_valid, with an idle receiver:
//     push, errors, sort of under two entries, unused codes: straight to result
//     pop, peek: top entry read, then result staged
//     pop-bottom: bottom read, then entries moved down (one RAM move per cycle)
//     sorted insert: direct write on an empty stack, else a scan down from the
//     top that moves each smaller entry up one place (one compare per cycle)
//     sort: each entry in turn is inserted into the sorted part below it
//     (insertion sort); the RAM port sets the pace.
//   Reset clears the fill count and the handshake state; RAM contents are
//   never cleared and never read above the fill count.
//   A stalled receiver holds the output register; a later finished result
//   waits in the result state, and no new request is taken until it moves on.
module sorting_lifo_stack_core
    import sls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sls_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sls_rsp_t out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;  // top entry read in flight
    localparam logic [2:0] S_PB0  = 3'd2;  // bottom entry read in flight
    localparam logic [2:0] S_PBS  = 3'd3;  // shifting entries down
    localparam logic [2:0] S_SLD  = 3'd4;  // sort: next key read in flight
    localparam logic [2:0] S_CMP  = 3'd5;  // insert scan, compare and move
    localparam logic [2:0] S_FIN  = 3'd6;  // key lands at bottom
    localparam logic [2:0] S_RES  = 3'd7;  // result staged

    // entry memory
    logic [31:0] mem [DEPTH];
    logic        we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;
    logic        re;
    logic [AW-1:0] raddr;
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // sequencer state
    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      pos_reg, pos_next;   // hole position during insert scan
    logic [AW-1:0]      idx_reg, idx_next;   // sort key index / shift index
    logic signed [31:0] key_reg, key_next;   // value being inserted
    logic               sort_reg, sort_next; // insert scan runs inside sort
    logic [2:0]         cmd_reg, cmd_next;
    logic signed [31:0] res_val_reg, res_val_next;
    logic [1:0]         res_stat_reg, res_stat_next;
    logic               out_valid_reg, out_valid_next;
    sls_rsp_t           out_data_reg, out_data_next;

    logic [CW-1:0] idx_plus1;
    logic          more_keys;

    assign idx_plus1 = CW'(idx_reg) + CW'(1);
    assign more_keys = idx_plus1 < fill_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        sort_next      = sort_reg;
        cmd_next       = cmd_reg;
        res_val_next   = res_val_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_val_next  = '0;
                    res_stat_next = STAT_OK;
                    cmd_next      = in_data.cmd;
                    state_next    = S_RES;
                    case (in_data.cmd)
                        CMD_PUSH:
                        begin
                            if (fill_reg == CW'(DEPTH))
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = fill_reg[AW-1:0];
                                wdata     = in_data.value_in;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = AW'(fill_reg - CW'(1));
                                state_next = S_POP;
                            end
                        end
                        CMD_POP_BOT:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = '0;
                                state_next = S_PB0;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (fill_reg > CW'(1))
                            begin
                                re         = 1'b1;
                                raddr      = AW'(1);
                                idx_next   = AW'(1);
                                sort_next  = 1'b1;
                                state_next = S_SLD;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (fill_reg == CW'(DEPTH))
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else if (fill_reg == '0)
                            begin
                                we        = 1'b1;
                                waddr     = '0;
                                wdata     = in_data.value_in;
                                fill_next = CW'(1);
                            end
                            else
                            begin
                                key_next   = in_data.value_in;
                                sort_next  = 1'b0;
                                pos_next   = fill_reg[AW-1:0];
                                re         = 1'b1;
                                raddr      = AW'(fill_reg - CW'(1));
                                state_next = S_CMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                res_val_next = rdata_reg;
                if (cmd_reg == CMD_POP)
                begin
                    fill_next = fill_reg - CW'(1);
                end
                state_next = S_RES;
            end

            S_PB0:
            begin
                res_val_next = rdata_reg;
                if (fill_reg > CW'(1))
                begin
                    re         = 1'b1;
                    raddr      = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_PBS;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RES;
                end
            end

            S_PBS:
            begin
                // entry idx arrives, lands one place lower
                we    = 1'b1;
                waddr = idx_reg - AW'(1);
                wdata = rdata_reg;
                if (more_keys)
                begin
                    re       = 1'b1;
                    raddr    = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RES;
                end
            end

            S_SLD:
            begin
                key_next   = rdata_reg;
                pos_next   = idx_reg;
                re         = 1'b1;
                raddr      = idx_reg - AW'(1);
                state_next = S_CMP;
            end

            S_CMP, S_FIN:
            begin
                // rdata holds entry pos-1 in S_CMP
                if (state_reg == S_CMP && $signed(rdata_reg) < key_reg)
                begin
                    we    = 1'b1;
                    waddr = pos_reg;
                    wdata = rdata_reg;
                    if (pos_reg == AW'(1))
                    begin
                        pos_next   = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = pos_reg - AW'(2);
                        pos_next = pos_reg - AW'(1);
                    end
                end
                else
                begin
                    // key goes into the hole; reads below stay clear of it
                    we    = 1'b1;
                    waddr = pos_reg;
                    wdata = key_reg;
                    if (sort_reg)
                    begin
                        if (more_keys)
                        begin
                            re         = 1'b1;
                            raddr      = idx_reg + AW'(1);
                            idx_next   = idx_reg + AW'(1);
                            state_next = S_SLD;
                        end
                        else
                        begin
                            state_next = S_RES;
                        end
                    end
                    else
                    begin
                        fill_next  = fill_reg + CW'(1);
                        state_next = S_RES;
                    end
                end
            end

            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.value_out = res_val_reg;
                    out_data_next.status    = res_stat_reg;
                    out_data_next.count     = 7'(fill_reg);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            sort_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            sort_reg      <= sort_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        cmd_reg      <= cmd_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        out_data_reg <= out_data_next;
    end

endmodule
